// ===== rtl/core/bgtr_pkg.sv =====
// Shared types, constants and codes for the bitmap glyph text renderer.
package bgtr_pkg;

  localparam int FONT_STORE_BYTES_DEF = 8192;
  localparam int GLYPH_ROWS_DEF       = 16;

  localparam int FONT_W      = 8;
  localparam int FONT_ADDR_W = 13;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 32;
  localparam int ADDR_OUT_W  = 33;
  localparam int FB_W        = 32;
  localparam int PITCH_W     = 15;
  localparam int GBYTES_W    = 6;
  localparam int LAST_COL_W  = 12;
  localparam int LAST_ROW_W  = 11;
  localparam int COL_W       = 11;
  localparam int ROW_W       = 10;
  localparam int GBASE_W     = CHAR_W + GBYTES_W;
  localparam int GSUM_W      = GBASE_W + 1;
  localparam int OFS_W       = 34;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PRINT = 1'b1;

  localparam logic [2:0] REG_FB_BASE     = 3'd0;
  localparam logic [2:0] REG_FB_SIZE     = 3'd1;
  localparam logic [2:0] REG_ROW_PITCH   = 3'd2;
  localparam logic [2:0] REG_GLYPH_BYTES = 3'd3;
  localparam logic [2:0] REG_LAST_COL    = 3'd4;
  localparam logic [2:0] REG_LAST_ROW    = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } row_ctrl_t;

endpackage

// ===== rtl/core/bgtr_font_store.sv =====
// Font store: single-port-write, registered-read glyph byte memory.
module bgtr_font_store
  import bgtr_pkg::*;
#(
  parameter int AW = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [FONT_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [FONT_W-1:0] rd_data
);

  logic [FONT_W-1:0] mem_r [2**AW];
  logic [FONT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bgtr_row_unit.sv =====
// Row unit: scan-line offset accumulator, pixel address adder and bounds mask.
module bgtr_row_unit
  import bgtr_pkg::*;
#(
  parameter int YW = 14
) (
  input  logic                  clk,
  input  row_ctrl_t             ctrl,
  input  logic [YW-1:0]         y0,
  input  logic [COL_W-1:0]      col,
  input  logic [PITCH_W-1:0]    row_pitch,
  input  logic [FB_W-1:0]       fb_base,
  input  logic [FB_W-1:0]       fb_size,
  input  logic [FONT_W-1:0]     glyph,
  output logic [ADDR_OUT_W-1:0] pixel_addr,
  output logic [FONT_W-1:0]     pixel_mask
);

  localparam int PROD_W = YW + PITCH_W;

  logic [OFS_W-1:0]  offset_r;
  logic [OFS_W-1:0]  offset_nxt;
  logic [PROD_W-1:0] prod;
  logic [OFS_W-1:0]  base_px;
  logic [OFS_W-1:0]  pitch4;
  logic [OFS_W:0]    addr_sum;
  logic [FB_W-1:0]   rem;
  logic              in_range;
  logic              rem_hi;

  // start offset in bytes: (col*8 + y0*pitch) * 4
  assign prod    = PROD_W'(y0) * PROD_W'(row_pitch);
  assign base_px = OFS_W'(prod) + OFS_W'({col, 3'b000});
  assign pitch4  = OFS_W'({row_pitch, 2'b00});

  always_comb begin
    offset_nxt = offset_r;
    if (ctrl.start) begin
      offset_nxt = {base_px[OFS_W-3:0], 2'b00};
    end else if (ctrl.step) begin
      offset_nxt = offset_r + pitch4;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
  end

  assign addr_sum   = (OFS_W + 1)'(fb_base) + (OFS_W + 1)'(offset_r);
  assign pixel_addr = addr_sum[ADDR_OUT_W-1:0];

  // pixel c passes when offset + 4c < fb_size
  assign in_range = offset_r < OFS_W'(fb_size);
  assign rem      = fb_size - offset_r[FB_W-1:0];
  assign rem_hi   = |rem[FB_W-1:5];

  always_comb begin
    pixel_mask = '0;
    for (int c = 0; c < FONT_W; c++) begin
      pixel_mask[FONT_W-1-c] = glyph[FONT_W-1-c] && in_range &&
                               (rem_hi || (rem[4:0] > 5'(4 * c)));
    end
  end

endmodule

// ===== rtl/core/bitmap_glyph_text_renderer_top.sv =====
// Top level: config registers, print sequencer, cursor and result register.
//
// Text console renderer for a 32-bit-per-pixel framebuffer.
// Input channel (in_valid/in_stall): a load beat (op 0) writes one font byte
// in the accept cycle and yields nothing. A print beat (op 1) yields
// GLYPH_ROWS row-write beats on the output channel, the final one with
// out_last set, then advances the text cursor.
// Sequence: after a print is accepted the sequencer passes through its START
// state, in which the first glyph row is read, then emits one row per cycle
// while the receiver takes them, paced by the single font store read port
// and the shared offset accumulator. in_stall is high while a print is in
// progress, from the START state until its final row has entered the output
// register; loads never raise in_stall.
// Output stall: the result register holds its beat and the sequencer waits;
// nothing is dropped.
// Reset (rst_n low, synchronous): cursor to column 0 row 0, registers to
// their defaults, no beat pending. The font store is not cleared; glyphs must
// be loaded before printing. The user must write the registers over the APB
// port only while the block is idle; the block itself does not enforce this.
module bitmap_glyph_text_renderer_top
  import bgtr_pkg::*;
#(
  parameter int FONT_STORE_BYTES = FONT_STORE_BYTES_DEF,
  parameter int GLYPH_ROWS       = GLYPH_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_op,
  input  logic [FONT_ADDR_W-1:0] in_font_addr,
  input  logic [FONT_W-1:0]      in_font_byte,
  input  logic [CHAR_W-1:0]      in_char_code,
  input  logic [COLOR_W-1:0]     in_color,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ADDR_OUT_W-1:0]  out_pixel_addr,
  output logic [FONT_W-1:0]      out_pixel_mask,
  output logic [COLOR_W-1:0]     out_pixel_color,
  output logic                   out_last,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int AW   = $clog2(FONT_STORE_BYTES);
  localparam int RW   = $clog2(GLYPH_ROWS);
  localparam int YW   = $clog2(1024 * GLYPH_ROWS);
  localparam int FAXW = (AW > FONT_ADDR_W) ? AW : FONT_ADDR_W;
  localparam int GAXW = (AW > GSUM_W) ? AW : GSUM_W;

  // configuration registers
  logic [FB_W-1:0]       fb_base_r;
  logic [FB_W-1:0]       fb_size_r;
  logic [PITCH_W-1:0]    row_pitch_r;
  logic [GBYTES_W-1:0]   glyph_bytes_r;
  logic [LAST_COL_W-1:0] last_col_r;
  logic [LAST_ROW_W-1:0] last_row_r;
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_base_r     <= '0;
      fb_size_r     <= FB_W'(4194304);
      row_pitch_r   <= PITCH_W'(1024);
      glyph_bytes_r <= GBYTES_W'(16);
      last_col_r    <= LAST_COL_W'(128);
      last_row_r    <= LAST_ROW_W'(48);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FB_BASE:     fb_base_r     <= pwdata;
        REG_FB_SIZE:     fb_size_r     <= pwdata;
        REG_ROW_PITCH:   row_pitch_r   <= pwdata[PITCH_W-1:0];
        REG_GLYPH_BYTES: glyph_bytes_r <= pwdata[GBYTES_W-1:0];
        REG_LAST_COL:    last_col_r    <= pwdata[LAST_COL_W-1:0];
        REG_LAST_ROW:    last_row_r    <= pwdata[LAST_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FB_BASE:     prdata = fb_base_r;
      REG_FB_SIZE:     prdata = fb_size_r;
      REG_ROW_PITCH:   prdata = APB_DW'(row_pitch_r);
      REG_GLYPH_BYTES: prdata = APB_DW'(glyph_bytes_r);
      REG_LAST_COL:    prdata = APB_DW'(last_col_r);
      REG_LAST_ROW:    prdata = APB_DW'(last_row_r);
      default:         prdata = '0;
    endcase
  end

  // sequencer
  seq_state_t          state_r;
  seq_state_t          state_nxt;
  logic [RW-1:0]       row_r;
  logic                row_last;
  logic [RW:0]         rd_row;
  logic                rd_en;
  logic                emit;
  logic                out_free;
  logic                in_accept;
  row_ctrl_t           ctrl;

  logic [COL_W-1:0]    cursor_col_r;
  logic [COL_W-1:0]    cursor_col_nxt;
  logic [ROW_W-1:0]    cursor_row_r;
  logic [ROW_W-1:0]    cursor_row_nxt;
  logic [LAST_COL_W-1:0] col_inc;

  logic [GBASE_W-1:0]  gbase_r;
  logic [YW-1:0]       y0_r;
  logic [COLOR_W-1:0]  color_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign row_last  = (row_r == RW'(GLYPH_ROWS - 1));

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_row    = '0;
    ctrl      = '0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_op == OP_PRINT) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        rd_en      = 1'b1;
        ctrl.start = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          rd_en     = 1'b1;
          // prefetch the next glyph row while this one goes out
          rd_row    = (RW + 1)'(row_r) + (RW + 1)'(1);
          ctrl.step = 1'b1;
          if (row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_START) begin
        row_r <= '0;
      end else if (emit) begin
        row_r <= row_r + RW'(1);
      end
    end
  end

  // cursor advance after the final row of a character
  always_comb begin
    col_inc        = LAST_COL_W'(cursor_col_r) + LAST_COL_W'(1);
    cursor_col_nxt = col_inc[COL_W-1:0];
    cursor_row_nxt = cursor_row_r;
    if (col_inc > last_col_r) begin
      cursor_col_nxt = '0;
      if (LAST_ROW_W'(cursor_row_r) < last_row_r) begin
        cursor_row_nxt = cursor_row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else if (emit && row_last) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_PRINT) begin
      gbase_r <= GBASE_W'(in_char_code) * GBASE_W'(glyph_bytes_r);
      y0_r    <= YW'(cursor_row_r) * YW'(GLYPH_ROWS);
      color_r <= in_color;
    end
  end

  // font store addressing, modulo the store size
  logic [FAXW-1:0]   wr_addr_ext;
  logic [GAXW-1:0]   rd_addr_ext;
  logic [FONT_W-1:0] glyph;
  logic              font_wr;

  assign font_wr     = in_accept && in_op == OP_LOAD;
  assign wr_addr_ext = FAXW'(in_font_addr);
  assign rd_addr_ext = GAXW'(GSUM_W'(gbase_r) + GSUM_W'(rd_row));

  bgtr_font_store #(
    .AW(AW)
  ) u_font_store (
    .clk     (clk),
    .wr_en   (font_wr),
    .wr_addr (wr_addr_ext[AW-1:0]),
    .wr_data (in_font_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_ext[AW-1:0]),
    .rd_data (glyph)
  );

  logic [ADDR_OUT_W-1:0] row_addr;
  logic [FONT_W-1:0]     row_mask;

  bgtr_row_unit #(
    .YW(YW)
  ) u_row_unit (
    .clk        (clk),
    .ctrl       (ctrl),
    .y0         (y0_r),
    .col        (cursor_col_r),
    .row_pitch  (row_pitch_r),
    .fb_base    (fb_base_r),
    .fb_size    (fb_size_r),
    .glyph      (glyph),
    .pixel_addr (row_addr),
    .pixel_mask (row_mask)
  );

  // result register
  logic                  out_valid_r;
  logic [ADDR_OUT_W-1:0] out_pixel_addr_r;
  logic [FONT_W-1:0]     out_pixel_mask_r;
  logic [COLOR_W-1:0]    out_pixel_color_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_addr_r  <= row_addr;
      out_pixel_mask_r  <= row_mask;
      out_pixel_color_r <= color_r;
      out_last_r        <= row_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_addr  = out_pixel_addr_r;
  assign out_pixel_mask  = out_pixel_mask_r;
  assign out_pixel_color = out_pixel_color_r;
  assign out_last        = out_last_r;

endmodule
